// File: rtl/core/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// Shared widths, codes and pipeline types for the point constraint checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrc_pkg;

   // coordinate handling
   localparam int COORD_WIDTH = 32;            // used low bits of each coordinate
   localparam int FIELD_W     = 32;            // coordinate port width
   localparam int ABS_W       = COORD_WIDTH;   // |b - a| fits in coordinate width
   localparam int SQ_W        = 2 * ABS_W;     // one squared difference
   localparam int SUM_W       = SQ_W + 2;      // sum of three squares
   localparam int ROOT_W      = SUM_W / 2;     // floored square root
   localparam int REM_W       = ROOT_W + 1;    // root remainder, at most 2 * root

   // payload widths
   localparam int OP_W  = 2;
   localparam int TAG_W = 16;
   localparam int TGT_W = 32;
   localparam int RES_W = 34;

   // constraint kinds
   localparam logic [OP_W-1:0] OP_COINCIDENT = 2'd0;
   localparam logic [OP_W-1:0] OP_DISTANCE   = 2'd1;

   // fields that ride along the pipeline untouched
   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic             present;
      logic [TAG_W-1:0] tag;
      logic [TGT_W-1:0] target;
   } side_type;

   // working set of one square root step
   typedef struct packed {
      logic [SUM_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

endpackage

`default_nettype wire

// File: rtl/core/pcrc_square_sum.sv
// ----------------------------------------------------------------------------
// pcrc_square_sum
// Three stages: per-axis absolute difference, squares, sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_square_sum import pcrc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire side_type           in_side,
   input  wire logic [FIELD_W-1:0] first_x,
   input  wire logic [FIELD_W-1:0] first_y,
   input  wire logic [FIELD_W-1:0] first_z,
   input  wire logic [FIELD_W-1:0] second_x,
   input  wire logic [FIELD_W-1:0] second_y,
   input  wire logic [FIELD_W-1:0] second_z,
   output logic                    out_valid,
   output side_type                out_side,
   output logic [SUM_W-1:0]        out_sum
);

   // magnitude of b - a over the low coordinate bits, sign extended
   function automatic logic [ABS_W-1:0] abs_diff(input logic [FIELD_W-1:0] a,
                                                 input logic [FIELD_W-1:0] b);
      logic [COORD_WIDTH:0] d;
      logic [COORD_WIDTH:0] m;
      d = {b[COORD_WIDTH-1], b[COORD_WIDTH-1:0]} - {a[COORD_WIDTH-1], a[COORD_WIDTH-1:0]};
      m = d[COORD_WIDTH] ? (~d + 1'b1) : d;
      return m[ABS_W-1:0];
   endfunction

   logic              v1_ff, v2_ff, v3_ff;
   side_type          s1_ff, s2_ff, s3_ff;
   logic [ABS_W-1:0]  dx_ff, dy_ff, dz_ff;
   logic [ABS_W-1:0]  dx_in, dy_in, dz_in;
   logic [SQ_W-1:0]   qx_ff, qy_ff, qz_ff;
   logic [SQ_W-1:0]   qx_in, qy_in, qz_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // stage 1: absolute differences
   assign dx_in = abs_diff(first_x, second_x);
   assign dy_in = abs_diff(first_y, second_y);
   assign dz_in = abs_diff(first_z, second_z);

   // stage 2: squares
   assign qx_in = SQ_W'(dx_ff) * SQ_W'(dx_ff);
   assign qy_in = SQ_W'(dy_ff) * SQ_W'(dy_ff);
   assign qz_in = SQ_W'(dz_ff) * SQ_W'(dz_ff);

   // stage 3: sum of squares
   assign sum_in = SUM_W'(qx_ff) + SUM_W'(qy_ff) + SUM_W'(qz_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= in_side;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz_ff  <= dz_in;
         s2_ff  <= s1_ff;
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         qz_ff  <= qz_in;
         s3_ff  <= s2_ff;
         sum_ff <= sum_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_side  = s3_ff;
   assign out_sum   = sum_ff;

endmodule

`default_nettype wire

// File: rtl/core/pcrc_isqrt_stage.sv
// ----------------------------------------------------------------------------
// pcrc_isqrt_stage
// One registered step of the digit-by-digit square root: one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_isqrt_stage import pcrc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire side_type in_side,
   input  wire sqrt_type in_work,
   output logic          out_valid,
   output side_type      out_side,
   output sqrt_type      out_work
);

   logic               valid_ff;
   side_type           side_ff;
   sqrt_type           work_ff, work_in;
   logic [REM_W+1:0]   trial;
   logic [REM_W+1:0]   test;
   logic [REM_W+1:0]   diff;
   logic               take;

   // bring down the next radicand pair and try root bit one
   assign trial = {in_work.rem, in_work.rad[SUM_W-1 -: 2]};
   assign test  = {1'b0, in_work.root, 2'b01};
   assign diff  = trial - test;
   assign take  = (trial >= test);

   always_comb begin
      work_in.rad  = {in_work.rad[SUM_W-3:0], 2'b00};
      work_in.rem  = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
      work_in.root = {in_work.root[ROOT_W-2:0], take};
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // data
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

// File: rtl/core/pcrc_residual.sv
// ----------------------------------------------------------------------------
// pcrc_residual
// Residual select, then tolerance compare into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_residual import pcrc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire side_type          in_side,
   input  wire logic [ROOT_W-1:0] in_root,
   input  wire logic [RES_W-1:0]  tolerance,
   output logic                   out_valid,
   output logic [TAG_W-1:0]       out_tag,
   output logic [RES_W-1:0]       out_residual,
   output logic                   out_satisfied
);

   logic               rv_ff, ov_ff;
   logic [TAG_W-1:0]   rtag_ff, otag_ff;
   logic [RES_W-1:0]   res_ff, res_in;
   logic [RES_W-1:0]   ores_ff;
   logic               sat_ff, sat_in;
   logic [RES_W:0]     up;
   logic [RES_W:0]     down;

   // |root - target|, sign of one subtraction picks the other
   assign up   = (RES_W + 1)'(in_root) - (RES_W + 1)'(in_side.target);
   assign down = (RES_W + 1)'(in_side.target) - (RES_W + 1)'(in_root);

   always_comb begin
      res_in = '0;
      if (in_side.present) begin
         case (in_side.opcode)
            OP_COINCIDENT: res_in = RES_W'(in_root);
            OP_DISTANCE:   res_in = up[RES_W] ? down[RES_W-1:0] : up[RES_W-1:0];
            default:       res_in = '0;
         endcase
      end
   end

   // satisfied when strictly below tolerance
   assign sat_in = (res_ff < tolerance);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= in_valid;
         ov_ff <= rv_ff;
      end
   end

   // data
   always_ff @(posedge clock) begin
      if (en) begin
         rtag_ff <= in_side.tag;
         res_ff  <= res_in;
         otag_ff <= rtag_ff;
         ores_ff <= res_ff;
         sat_ff  <= sat_in;
      end
   end

   assign out_valid     = ov_ff;
   assign out_tag       = otag_ff;
   assign out_residual  = ores_ff;
   assign out_satisfied = sat_ff;

endmodule

`default_nettype wire

// File: rtl/core/point_constraint_residual_check_unit.sv
// ----------------------------------------------------------------------------
// point_constraint_residual_check_unit: distance residual of a point pair
// Stages: 3 difference/square/sum stages, 33 root stages, then the residual registers.
// Throughput: one beat per cycle, except while rsp_stall holds a valid response.
// Reset clears all valid bits and the tolerance register to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module point_constraint_residual_check_unit import pcrc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [OP_W-1:0]    req_opcode,
   input  wire logic               req_operands_present,
   input  wire logic [TAG_W-1:0]   req_constraint_tag,
   input  wire logic [FIELD_W-1:0] req_first_x,
   input  wire logic [FIELD_W-1:0] req_first_y,
   input  wire logic [FIELD_W-1:0] req_first_z,
   input  wire logic [FIELD_W-1:0] req_second_x,
   input  wire logic [FIELD_W-1:0] req_second_y,
   input  wire logic [FIELD_W-1:0] req_second_z,
   input  wire logic [TGT_W-1:0]   req_target_distance,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [TAG_W-1:0]        rsp_result_tag,
   output logic [RES_W-1:0]        rsp_residual,
   output logic                    rsp_satisfied,
   // tolerance register
   input  wire logic               csr_wr_en,
   input  wire logic [RES_W-1:0]   csr_wr_data
);

   logic               en;
   logic [RES_W-1:0]   tolerance_ff;
   side_type           req_side;
   logic               sum_valid;
   side_type           sum_side;
   logic [SUM_W-1:0]   sum_value;
   logic               chain_valid [ROOT_W+1];
   side_type           chain_side  [ROOT_W+1];
   sqrt_type           chain_work  [ROOT_W+1];

   // whole pipe advances whenever the output register can move
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= '0;
      end else if (csr_wr_en) begin
         tolerance_ff <= csr_wr_data;
      end
   end

   // sideband for the request beat
   always_comb begin
      req_side.opcode  = req_opcode;
      req_side.present = req_operands_present;
      req_side.tag     = req_constraint_tag;
      req_side.target  = req_target_distance;
   end

   // differences, squares and sum
   pcrc_square_sum u_square_sum (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_side   (req_side),
      .first_x   (req_first_x),
      .first_y   (req_first_y),
      .first_z   (req_first_z),
      .second_x  (req_second_x),
      .second_y  (req_second_y),
      .second_z  (req_second_z),
      .out_valid (sum_valid),
      .out_side  (sum_side),
      .out_sum   (sum_value)
   );

   // square root chain, one root bit per stage; head is radicand, zero rem and root
   assign chain_valid[0] = sum_valid;
   assign chain_side[0]  = sum_side;
   assign chain_work[0]  = {sum_value, {REM_W{1'b0}}, {ROOT_W{1'b0}}};

   for (genvar i = 0; i < ROOT_W; i++) begin : g_root
      pcrc_isqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[i]),
         .in_side   (chain_side[i]),
         .in_work   (chain_work[i]),
         .out_valid (chain_valid[i+1]),
         .out_side  (chain_side[i+1]),
         .out_work  (chain_work[i+1])
      );
   end

   // residual and tolerance compare
   pcrc_residual u_residual (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (chain_valid[ROOT_W]),
      .in_side       (chain_side[ROOT_W]),
      .in_root       (chain_work[ROOT_W].root),
      .tolerance     (tolerance_ff),
      .out_valid     (rsp_valid),
      .out_tag       (rsp_result_tag),
      .out_residual  (rsp_residual),
      .out_satisfied (rsp_satisfied)
   );

endmodule

`default_nettype wire
